/* design/sfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Framing codes, result kinds and the types shared by the decoder modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int COUNT_W = 15;

    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    localparam logic [COUNT_W-1:0] RESET_MAX_LEN = 15'd16384;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic   esc;
        t_count count;
    } t_dec_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [1:0] out_kind;
    } t_dec_result;

endpackage : sfd_pkg
`default_nettype wire

/* design/sfd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SLIP frame decoder channels
// Valid/ready channels for received bytes, decoded results and the limit write.
// ----------------------------------------------------------------------------
interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface : sfd_rx_if

interface sfd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;

    modport source (output valid, output out_byte, output out_kind, input ready);
    modport sink   (input valid, input out_byte, input out_kind, output ready);
endinterface : sfd_res_if

interface sfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] max_packet_len;

    modport source (output valid, output max_packet_len, input ready);
    modport sink   (input valid, input max_packet_len, output ready);
endinterface : sfd_cfg_if
`default_nettype wire

/* design/sfd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SLIP frame decoder step
// Next escape flag, next byte count and the optional result for one byte.
// ----------------------------------------------------------------------------
module sfd_decode (
    input  sfd_pkg::t_dec_state  i_state,
    input  logic [7:0]           i_byte,
    input  sfd_pkg::t_count      i_limit,
    output sfd_pkg::t_dec_state  o_next,
    output sfd_pkg::t_dec_result o_res
);
    import sfd_pkg::*;

    logic                 data_take;
    logic [7:0]           data_byte;
    logic [COUNT_W:0]     count_inc;

    assign count_inc = {1'b0, i_state.count} + {{COUNT_W{1'b0}}, 1'b1};

    always_comb begin
        o_next    = i_state;
        o_res     = '{valid: 1'b0, out_byte: 8'd0, out_kind: KIND_DATA};
        data_take = 1'b0;
        data_byte = i_byte;

        if (i_state.esc) begin
            // Any byte after ESC is data; only the two escape codes are mapped.
            o_next.esc = 1'b0;
            data_take  = 1'b1;
            case (i_byte)
                CODE_ESC_END: data_byte = CODE_END;
                CODE_ESC_ESC: data_byte = CODE_ESC;
                default:      data_byte = i_byte;
            endcase
        end else if (i_byte == CODE_END) begin
            if (i_state.count != '0) begin
                o_next.count   = '0;
                o_res.valid    = 1'b1;
                o_res.out_kind = KIND_END;
            end
        end else if (i_byte == CODE_ESC) begin
            o_next.esc = 1'b1;
        end else begin
            data_take = 1'b1;
        end

        if (data_take) begin
            o_res.valid = 1'b1;
            if (count_inc > {1'b0, i_limit}) begin
                o_next.count   = '0;
                o_res.out_kind = KIND_DISCARD;
            end else begin
                o_next.count   = count_inc[COUNT_W-1:0];
                o_res.out_byte = data_byte;
            end
        end
    end

endmodule : sfd_decode
`default_nettype wire

/* design/slip_frame_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Removes SLIP framing from a received byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while input ready is high
// and gives at most one result for it: a data byte, an end-of-packet marker or
// a discard marker when a packet grows past max_packet_len. The result appears
// in the output register in the cycle after the byte's transfer; the escape
// flag and byte count update in that same cycle, so back-to-back bytes run at
// one per cycle. Input ready stays high while the output register is empty or
// being taken, so the output register alone decouples the two sides. Lone ESC
// bytes and END bytes with no data before them give no result. The limit
// resets to 16384 and may be written only while the block is idle.
module slip_frame_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfd_rx_if.sink    i_rx,
    sfd_res_if.source o_res,
    sfd_cfg_if.sink   i_cfg
);
    import sfd_pkg::*;

    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result dec_res;
    t_count      r_limit;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_kind;
    logic        rx_xfer;

    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;
    assign rx_xfer     = i_rx.valid && i_rx.ready;

    assign o_res.valid    = r_out_valid;
    assign o_res.out_byte = r_out_byte;
    assign o_res.out_kind = r_out_kind;

    sfd_decode u_decode (
        .i_state (r_state),
        .i_byte  (i_rx.rx_byte),
        .i_limit (r_limit),
        .o_next  (n_state),
        .o_res   (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{esc: 1'b0, count: '0};
            r_limit     <= RESET_MAX_LEN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.max_packet_len;
            end
            if (rx_xfer) begin
                r_state <= n_state;
            end
            if (rx_xfer && dec_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_xfer && dec_res.valid) begin
            r_out_byte <= dec_res.out_byte;
            r_out_kind <= dec_res.out_kind;
        end
    end

`ifndef SYNTHESIS
    // Markers never carry a byte, and the unused kind code never appears.
    a_marker_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind != KIND_DATA) |-> (r_out_byte == 8'd0))
        else $error("marker result carries a nonzero byte");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_kind == KIND_DATA) || (r_out_kind == KIND_END) ||
                         (r_out_kind == KIND_DISCARD)))
        else $error("result kind out of range");

    // A fresh ESC arms the flag; any byte taken while armed clears it.
    a_esc_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer && !r_state.esc && (i_rx.rx_byte == CODE_ESC) |=> r_state.esc)
        else $error("ESC did not arm the escape flag");

    a_esc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer && r_state.esc |=> !r_state.esc && r_out_valid)
        else $error("escaped byte did not clear the flag or give a result");
`endif

endmodule : slip_frame_decoder
`default_nettype wire
